@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker in bfiq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge while out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked while out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/bfiq_pkg.sv @@
package bfiq_pkg;

  localparam int unsigned MaxFilterBytes = 32768;
  localparam int unsigned MaxKeyBytes    = 128;
  localparam int unsigned MaxHashes      = 50;

  localparam int unsigned StoreAw = $clog2(MaxFilterBytes);
  localparam int unsigned KeyAw   = $clog2(MaxKeyBytes);
  // Wide enough for the bit count of a full store and for the doubled
  // partial remainder of the modulo step.
  localparam int unsigned BitIdxW = StoreAw + 4;

  localparam logic [31:0] SeedStep = 32'hFBA4C795;
  localparam logic [31:0] MurC1    = 32'hcc9e2d51;
  localparam logic [31:0] MurC2    = 32'h1b873593;
  localparam logic [31:0] MurAdd   = 32'he6546b64;
  localparam logic [31:0] MurF1    = 32'h85ebca6b;
  localparam logic [31:0] MurF2    = 32'hc2b2ae35;

  localparam logic [1:0] OpInsert    = 2'd0;
  localparam logic [1:0] OpQuery     = 2'd1;
  localparam logic [1:0] OpClear     = 2'd2;
  localparam logic [1:0] OpRecompute = 2'd3;

  localparam logic [1:0] CfgFilterBytes = 2'd0;
  localparam logic [1:0] CfgHashCount   = 2'd1;
  localparam logic [1:0] CfgTweak       = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] key_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic hit;
    logic key_too_long;
    logic is_full;
    logic is_empty;
  } out_word_t;

  function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage

@@ rtl/core/bfiq_ram.sv @@
module bfiq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/bloom_filter_insert_query_core.sv @@
// Bloom filter core: key words stream in one per cycle while idle with no result pending, and
// are hashed with MurmurHash3. An overlong key or a full or empty shortcut is answered
// straight from its last word; otherwise the hashes run in series, one after another.
// Clear zeroes the whole store and recompute scans the filter bytes in use; input stalls until
// the result word is taken, so commands run one at a time.
// Reset: marks and lengths clear, then an init pass zeroes the whole store, input stalled.
module bloom_filter_insert_query_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  bfiq_pkg::in_word_t       in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output bfiq_pkg::out_word_t      out_data_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i
);
  import bfiq_pkg::*;

  // Sequencer states.
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StInit  = 4'd1;
  localparam logic [3:0] StClear = 4'd2;
  localparam logic [3:0] StScan  = 4'd3;
  localparam logic [3:0] StSeed  = 4'd4;
  localparam logic [3:0] StByte  = 4'd5;
  localparam logic [3:0] StMix1  = 4'd6;
  localparam logic [3:0] StMix2  = 4'd7;
  localparam logic [3:0] StFin   = 4'd8;
  localparam logic [3:0] StMod   = 4'd9;
  localparam logic [3:0] StRd    = 4'd10;
  localparam logic [3:0] StWr    = 4'd11;
  localparam logic [3:0] StOut   = 4'd12;
  localparam logic [3:0] StScanE = 4'd13;

  logic [3:0] state_q, state_d;

  // Configuration registers.
  logic [15:0] filter_bytes_q;
  logic [5:0]  hash_count_q;
  logic [31:0] tweak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_bytes_q <= 16'd32768;
      hash_count_q   <= 6'd1;
      tweak_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFilterBytes: filter_bytes_q <= cfg_data_i[15:0];
        CfgHashCount:   hash_count_q   <= cfg_data_i[5:0];
        CfgTweak:       tweak_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped sizes in use.
  logic [StoreAw:0] bytes_use;
  logic [5:0]       hashes_use;
  assign bytes_use = (filter_bytes_q == 16'd0) ? (StoreAw+1)'(1) :
                     ({1'b0, filter_bytes_q} > 17'(MaxFilterBytes)) ? (StoreAw+1)'(MaxFilterBytes) :
                     (StoreAw+1)'(filter_bytes_q);
  assign hashes_use = (hash_count_q > 6'(MaxHashes)) ? 6'(MaxHashes) : hash_count_q;

  // Key buffer memory.
  logic             kb_we;
  logic [KeyAw-1:0] kb_waddr, kb_raddr;
  logic [7:0]       kb_rdata;

  bfiq_ram #(.Width(8), .Depth(MaxKeyBytes)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kb_we),
    .waddr_i (kb_waddr),
    .wdata_i (in_data_i.key_byte),
    .raddr_i (kb_raddr),
    .rdata_o (kb_rdata)
  );

  // Filter store memory.
  logic               fs_we;
  logic [StoreAw-1:0] fs_waddr, fs_raddr;
  logic [7:0]         fs_wdata, fs_rdata;

  bfiq_ram #(.Width(8), .Depth(MaxFilterBytes)) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  // Datapath registers.
  logic [KeyAw:0]     key_len_q, key_len_d;
  logic               ovf_q, ovf_d;
  logic               full_q, full_d, empty_q, empty_d;
  logic [1:0]         op_q, op_d;
  logic [5:0]         hidx_q, hidx_d;
  logic [31:0]        seed_q, seed_d;
  logic [31:0]        h_q, h_d, k_q, k_d;
  logic [KeyAw:0]     pos_q, pos_d;
  logic [StoreAw:0]   addr_q, addr_d;
  logic               hit_q, hit_d;
  logic               f_acc_q, f_acc_d, e_acc_q, e_acc_d;
  logic [2:0]         fin_q, fin_d;
  logic [BitIdxW-1:0] bidx_q, bidx_d;
  logic [5:0]         mstep_q, mstep_d;
  logic [BitIdxW+31:0] rem_q, rem_d;
  out_word_t          out_q, out_d;
  logic               ov_q, ov_d;

  logic in_acc, out_acc;
  assign in_stall_o  = (state_q != StIdle) || ov_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = ov_q && !out_stall_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  logic [BitIdxW-1:0] nbits;
  assign nbits = BitIdxW'(bytes_use) << 3;

  logic [31:0] k_mix;
  logic [1:0]  rem_bytes;
  assign rem_bytes = key_len_q[1:0];
  assign k_mix     = rotl32(k_q * MurC1, 15);

  always_comb begin
    state_d = state_q;
    key_len_d = key_len_q; ovf_d = ovf_q; full_d = full_q; empty_d = empty_q;
    op_d = op_q; hidx_d = hidx_q; seed_d = seed_q; h_d = h_q; k_d = k_q;
    pos_d = pos_q; addr_d = addr_q; hit_d = hit_q; f_acc_d = f_acc_q;
    e_acc_d = e_acc_q; fin_d = fin_q; bidx_d = bidx_q; mstep_d = mstep_q;
    rem_d = rem_q; out_d = out_q; ov_d = ov_q;
    kb_we = 1'b0; kb_waddr = key_len_q[KeyAw-1:0]; kb_raddr = pos_q[KeyAw-1:0];
    fs_we = 1'b0; fs_waddr = addr_q[StoreAw-1:0]; fs_wdata = '0;
    fs_raddr = addr_q[StoreAw-1:0];
    if (out_acc) ov_d = 1'b0;
    case (state_q)
      StInit: begin
        fs_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == (StoreAw+1)'(MaxFilterBytes - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (in_acc) begin
          if (in_data_i.opcode == OpClear) begin
            key_len_d = '0; ovf_d = 1'b0; addr_d = '0; state_d = StClear;
          end else if (in_data_i.opcode == OpRecompute) begin
            key_len_d = '0; ovf_d = 1'b0; addr_d = '0; f_acc_d = 1'b1;
            e_acc_d = 1'b1; state_d = StScan;
          end else begin
            if (key_len_q < (KeyAw+1)'(MaxKeyBytes)) begin
              kb_we = 1'b1; key_len_d = key_len_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            if (in_data_i.last) begin
              op_d = in_data_i.opcode; hit_d = 1'b0;
              if (ovf_d) begin
                out_d = '{hit: 1'b0, key_too_long: 1'b1, is_full: full_q, is_empty: empty_q};
                ov_d = 1'b1; key_len_d = '0; ovf_d = 1'b0;
              end else if (full_q) begin
                out_d = '{hit: in_data_i.opcode == OpQuery, key_too_long: 1'b0,
                          is_full: 1'b1, is_empty: empty_q};
                ov_d = 1'b1; key_len_d = '0;
              end else if (in_data_i.opcode == OpQuery && empty_q) begin
                out_d = '{hit: 1'b0, key_too_long: 1'b0, is_full: 1'b0, is_empty: 1'b1};
                ov_d = 1'b1; key_len_d = '0;
              end else begin
                hidx_d = '0; hit_d = 1'b1; seed_d = tweak_q; state_d = StOut;
                if (hashes_use != 6'd0) state_d = StSeed;
              end
            end
          end
        end
      end
      StClear: begin
        fs_we = 1'b1; addr_d = addr_q + 1'b1;
        if (addr_q == (StoreAw+1)'(MaxFilterBytes - 1)) begin
          full_d = 1'b0; empty_d = 1'b1; op_d = OpClear; hit_d = 1'b0; state_d = StOut;
        end
      end
      StScan: begin
        // Read issued for addr_q; data checked next cycle.
        addr_d = addr_q + 1'b1; state_d = StScanE;
      end
      StScanE: begin
        f_acc_d = f_acc_q && (fs_rdata == 8'hff);
        e_acc_d = e_acc_q && (fs_rdata == 8'h00);
        if (addr_q == bytes_use) begin
          full_d = f_acc_d; empty_d = e_acc_d; op_d = OpRecompute; hit_d = 1'b0;
          state_d = StOut;
        end else begin
          addr_d = addr_q + 1'b1;
          fs_raddr = addr_q[StoreAw-1:0];
        end
      end
      StSeed: begin
        h_d = seed_q; k_d = '0; pos_d = '0; fin_d = 3'd0; state_d = StByte;
      end
      StByte: begin
        // Byte pos_q - 1 was read last cycle (or, at pos_q zero, the first read is issued now).
        if (pos_q == key_len_q + 1'b1 || (pos_q[1:0] == 2'd0 && pos_q != 0 &&
            pos_q <= key_len_q && 1'b0)) begin
          state_d = StByte;
        end
        if (pos_q != 0) begin
          k_d = k_q | (32'(kb_rdata) << {pos_q[1:0] - 2'd1, 3'b000});
        end
        if (pos_q != 0 && pos_q[1:0] == 2'd0) begin
          state_d = StMix1; // full block collected
        end else if (pos_q == key_len_q && !(pos_q != 0 && pos_q[1:0] == 2'd0)) begin
          if (pos_q != 0) fin_d = 3'd0;
          state_d = (rem_bytes != 2'd0) ? StMix1 : StFin;
          fin_d = 3'd0;
        end
        pos_d = pos_q + 1'b1;
        kb_raddr = pos_q[KeyAw-1:0];
      end
      StMix1: begin
        k_d = k_mix; state_d = StMix2;
      end
      StMix2: begin
        if (pos_q[1:0] == 2'd1 && pos_q - 1'b1 <= key_len_q && (pos_q - 1'b1) != key_len_q ||
            ((pos_q - 1'b1) == key_len_q && rem_bytes == 2'd0)) begin
          h_d = rotl32(h_q ^ (k_q * MurC2), 13) * 32'd5 + MurAdd;
        end else begin
          h_d = h_q ^ (k_q * MurC2);
        end
        k_d = '0;
        if ((pos_q - 1'b1) >= key_len_q && !((pos_q - 1'b1) == key_len_q && rem_bytes == 2'd0))
          state_d = StFin;
        else if ((pos_q - 1'b1) == key_len_q) begin
          state_d = StFin;
        end else begin
          // Refetch the byte whose read was displaced by the mixing cycles.
          kb_raddr = KeyAw'(pos_q - 1'b1);
          state_d = StByte;
        end
      end
      StFin: begin
        fin_d = fin_q + 1'b1;
        case (fin_q)
          3'd0: h_d = h_q ^ 32'(key_len_q);
          3'd1: h_d = h_q ^ (h_q >> 16);
          3'd2: h_d = h_q * MurF1;
          3'd3: h_d = h_q ^ (h_q >> 13);
          3'd4: h_d = h_q * MurF2;
          default: begin
            h_d = h_q ^ (h_q >> 16);
            rem_d = {BitIdxW'(0), h_d};
            mstep_d = '0;
            state_d = StMod;
          end
        endcase
      end
      StMod: begin
        // Restoring remainder, one bit a cycle from the top.
        rem_d = rem_q << 1;
        if (rem_d[BitIdxW+31:32] >= nbits)
          rem_d[BitIdxW+31:32] = rem_d[BitIdxW+31:32] - nbits;
        mstep_d = mstep_q + 1'b1;
        if (mstep_q == 6'd31) begin
          bidx_d = rem_d[BitIdxW+31:32];
          addr_d = (StoreAw+1)'(rem_d[BitIdxW+31:35]);
          state_d = StRd;
        end
      end
      StRd: begin
        fs_raddr = addr_q[StoreAw-1:0]; state_d = StWr;
      end
      StWr: begin
        if (op_q == OpInsert) begin
          fs_we = 1'b1; fs_wdata = fs_rdata | (8'd1 << bidx_q[2:0]);
        end else if (!fs_rdata[bidx_q[2:0]]) begin
          hit_d = 1'b0;
        end
        hidx_d = hidx_q + 1'b1;
        seed_d = seed_q + SeedStep;
        state_d = (hidx_q + 1'b1 == hashes_use) ? StOut : StSeed;
      end
      StOut: begin
        if (op_q == OpInsert) empty_d = 1'b0;
        out_d = '{hit: (op_q == OpQuery) && hit_q, key_too_long: 1'b0,
                  is_full: full_q, is_empty: (op_q == OpInsert) ? 1'b0 : empty_d};
        ov_d = 1'b1; key_len_d = '0; ovf_d = 1'b0; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit; key_len_q <= '0; ovf_q <= 1'b0; full_q <= 1'b0;
      empty_q <= 1'b0; ov_q <= 1'b0; addr_q <= '0; hidx_q <= '0;
      fin_q <= '0; mstep_q <= '0; pos_q <= '0;
    end else begin
      state_q <= state_d; key_len_q <= key_len_d; ovf_q <= ovf_d; full_q <= full_d;
      empty_q <= empty_d; ov_q <= ov_d; addr_q <= addr_d; hidx_q <= hidx_d;
      fin_q <= fin_d; mstep_q <= mstep_d; pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; seed_q <= seed_d; h_q <= h_d; k_q <= k_d; hit_q <= hit_d;
    f_acc_q <= f_acc_d; e_acc_q <= e_acc_d; bidx_q <= bidx_d; rem_q <= rem_d;
    out_q <= out_d;
  end

endmodule

@@ rtl/core/bfiq_checker.sv @@
`include "assert_macros.svh"
module bfiq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bfiq_pkg::out_word_t out_data_o
);
  // Output word holds while stalled.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  // A pending result blocks new input.
  `ASSERT_IMPL(a_in_blocked, clk_i, rst_ni, out_valid_o, in_stall_o)
  // Full and empty are never both reported.
  `ASSERT_IMPL(a_marks, clk_i, rst_ni, out_valid_o, !(out_data_o.is_full && out_data_o.is_empty))
  // An oversize key never reports a hit.
  `ASSERT_IMPL(a_long_nohit, clk_i, rst_ni, out_valid_o && out_data_o.key_too_long, !out_data_o.hit)
endmodule

bind bloom_filter_insert_query_core bfiq_checker u_bfiq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);
